// File: hdl/srl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_pkg
// Shared constants for the S-record loader: nibble store sizing, record
// scan phases and result kinds.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int NIBBLE_DEPTH = 128;
  localparam int ADDR_W       = $clog2(NIBBLE_DEPTH);
  localparam int FILL_W       = $clog2(NIBBLE_DEPTH + 1);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_S1   = 2'd2;
  localparam logic [1:0] PH_S9   = 2'd3;

  localparam logic [2:0] RK_WRITE = 3'd0;
  localparam logic [2:0] RK_LEN   = 3'd1;
  localparam logic [2:0] RK_SUM   = 3'd2;
  localparam logic [2:0] RK_LONG  = 3'd3;
  localparam logic [2:0] RK_DONE  = 3'd4;

  localparam logic [7:0]  SUM_OK  = 8'hFF;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  localparam logic [7:0] CH_S_UP = 8'h53;
  localparam logic [7:0] CH_S_LO = 8'h73;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_NINE = 8'h39;

endpackage

// File: hdl/srl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_in_if
// Character channel: one file character or an end-of-file marker per beat.
// ----------------------------------------------------------------------------
interface srl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] character;

  modport source (output valid, output kind, output character, input ready);
  modport sink (input valid, input kind, input character, output ready);
endinterface

// File: hdl/srl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_out_if
// Result channel: one byte write, error or done report per beat.
// ----------------------------------------------------------------------------
interface srl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic [15:0] record_number;
  logic        last;

  modport source (output valid, output result_kind, output write_address,
                  output write_data, output record_number, output last,
                  input ready);
  modport sink (input valid, input result_kind, input write_address,
                input write_data, input record_number, input last,
                output ready);
endinterface

// File: hdl/s_record_loader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s_record_loader
// Loader for S1/S9 S-record files that turns characters into byte writes.
// ----------------------------------------------------------------------------
// Each file character is taken while the loader is idle, and its hex digit goes
// into a nibble memory with one write and one registered read port. Closing a
// record (next 'S' of an S1 record, or end of file) sweeps that memory once to
// check length and byte sum, then reads it again to emit the writes, which
// output stalls hold up. No new character is taken until a close has loaded its
// last result into the output register. An end-of-file, error or too-long
// report waits for a free output register. An error halts the loader until the
// end-of-file beat, which always returns a done result with the record count
// and restarts the loader.
// ----------------------------------------------------------------------------
module s_record_loader (
  input  logic      clk,
  input  logic      rst,
  srl_in_if.sink    chars,
  srl_out_if.source results
);

  localparam int XW = srl_pkg::FILL_W + 2;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SUM   = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_ERR   = 4'd3;
  localparam logic [3:0] ST_WR_A  = 4'd4;
  localparam logic [3:0] ST_WR_B  = 4'd5;
  localparam logic [3:0] ST_WR_C  = 4'd6;
  localparam logic [3:0] ST_DONE  = 4'd7;
  localparam logic [3:0] ST_LONG  = 4'd8;

  logic [3:0]                  state;
  logic [srl_pkg::FILL_W-1:0]  fill;
  logic [1:0]                  phase;
  logic [15:0]                 counter;
  logic                        halted;
  logic                        eof_close;
  logic                        store_close;
  logic [srl_pkg::FILL_W-1:0]  idx;
  logic                        rd_vld;
  logic [srl_pkg::FILL_W-1:0]  rd_j;
  logic [3:0]                  hi;
  logic [7:0]                  len;
  logic [7:0]                  sum;
  logic [15:0]                 wr_addr;
  logic [2:0]                  err_kind;

  logic                        out_valid;
  logic [2:0]                  out_kind;
  logic [15:0]                 out_addr;
  logic [7:0]                  out_data;
  logic [15:0]                 out_rec;
  logic                        out_last;
  logic                        out_load;

  logic [3:0]                  mem [srl_pkg::NIBBLE_DEPTH];
  logic [3:0]                  rdata;
  logic                        mem_we;
  logic                        mem_re;
  logic [srl_pkg::ADDR_W-1:0]  raddr;

  logic                        in_acc;
  logic                        is_s;
  logic                        hex_ok;
  logic [3:0]                  hex_val;
  logic                        in_record;
  logic                        store_full;
  logic                        slot_free;
  logic [7:0]                  rd_byte;
  logic [9:0]                  expect_len;
  logic [XW-1:0]               idx_x;
  logic [XW-1:0]               fill_x;
  logic                        more_wr;
  logic                        any_wr;

  assign chars.ready           = (state == ST_IDLE);
  assign results.valid         = out_valid;
  assign results.result_kind   = out_kind;
  assign results.write_address = out_addr;
  assign results.write_data    = out_data;
  assign results.record_number = out_rec;
  assign results.last          = out_last;

  always_comb begin
    in_acc     = chars.valid & chars.ready;
    is_s       = (chars.character == srl_pkg::CH_S_UP) ||
                 (chars.character == srl_pkg::CH_S_LO);
    hex_ok     = 1'b1;
    hex_val    = 4'd0;
    if (chars.character inside {[8'h30:8'h39]}) begin
      hex_val = chars.character[3:0];
    end else if (chars.character inside {[8'h41:8'h46]}) begin
      hex_val = 4'(chars.character - 8'd55);
    end else if (chars.character inside {[8'h61:8'h66]}) begin
      hex_val = 4'(chars.character - 8'd87);
    end else begin
      hex_ok = 1'b0;
    end
    in_record  = (phase == srl_pkg::PH_S1) || (phase == srl_pkg::PH_S9);
    store_full = (XW'(fill) >= XW'(srl_pkg::NIBBLE_DEPTH));
    mem_we     = in_acc && !chars.kind && !halted && !is_s && in_record &&
                 !store_full && hex_ok;
    slot_free  = !out_valid || results.ready;
    out_load   = slot_free && (state inside {ST_ERR, ST_WR_C, ST_DONE, ST_LONG});
    rd_byte    = {hi, rdata};
    expect_len = ({2'b00, len} + 10'd1) << 1;
    idx_x      = XW'(idx);
    fill_x     = XW'(fill);
    more_wr    = (idx_x + XW'(5)) < fill_x;
    any_wr     = XW'(9) < fill_x;
    mem_re     = 1'b0;
    raddr      = idx[srl_pkg::ADDR_W-1:0];
    case (state)
      ST_SUM: begin
        mem_re = (idx != fill);
      end
      ST_WR_A: begin
        mem_re = 1'b1;
      end
      ST_WR_B: begin
        mem_re = 1'b1;
        raddr  = srl_pkg::ADDR_W'(idx + 1'b1);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill[srl_pkg::ADDR_W-1:0]] <= hex_val;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      phase     <= srl_pkg::PH_WAIT;
      counter   <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      rd_vld <= (state == ST_SUM) && mem_re;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (chars.kind) begin
              if (!halted && in_record) begin
                state       <= ST_SUM;
                eof_close   <= 1'b1;
                store_close <= (phase == srl_pkg::PH_S1);
                idx         <= '0;
                sum         <= '0;
                len         <= '0;
                hi          <= '0;
                wr_addr     <= '0;
              end else begin
                state <= ST_DONE;
              end
            end else if (!halted) begin
              if (is_s) begin
                if (phase == srl_pkg::PH_S1) begin
                  state       <= ST_SUM;
                  eof_close   <= 1'b0;
                  store_close <= 1'b1;
                  idx         <= '0;
                  sum         <= '0;
                  len         <= '0;
                  hi          <= '0;
                  wr_addr     <= '0;
                end else begin
                  if (counter != srl_pkg::CNT_MAX) begin
                    counter <= counter + 16'd1;
                  end
                  fill  <= '0;
                  phase <= srl_pkg::PH_TYPE;
                end
              end else begin
                case (phase)
                  srl_pkg::PH_TYPE: begin
                    if (chars.character == srl_pkg::CH_ONE) begin
                      phase <= srl_pkg::PH_S1;
                    end else if (chars.character == srl_pkg::CH_NINE) begin
                      phase <= srl_pkg::PH_S9;
                    end else begin
                      phase <= srl_pkg::PH_WAIT;
                    end
                  end
                  srl_pkg::PH_WAIT: begin
                    phase <= srl_pkg::PH_WAIT;
                  end
                  default: begin
                    if (store_full) begin
                      state <= ST_LONG;
                    end else if (hex_ok) begin
                      fill <= fill + 1'b1;
                    end
                  end
                endcase
              end
            end
          end
        end
        ST_SUM: begin
          if (mem_re) begin
            idx <= idx + 1'b1;
          end
          rd_j <= idx;
          if (rd_vld) begin
            if (!rd_j[0]) begin
              hi <= rdata;
            end else begin
              sum <= sum + rd_byte;
              if (rd_j == srl_pkg::FILL_W'(1)) begin
                len <= rd_byte;
              end
              if (rd_j == srl_pkg::FILL_W'(3)) begin
                wr_addr[15:8] <= rd_byte;
              end
              if (rd_j == srl_pkg::FILL_W'(5)) begin
                wr_addr[7:0] <= rd_byte;
              end
            end
          end
          if (!mem_re && !rd_vld) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (expect_len != 10'(fill)) begin
            err_kind <= srl_pkg::RK_LEN;
            state    <= ST_ERR;
          end else if (sum != srl_pkg::SUM_OK) begin
            err_kind <= srl_pkg::RK_SUM;
            state    <= ST_ERR;
          end else if (store_close && any_wr) begin
            idx   <= srl_pkg::FILL_W'(6);
            state <= ST_WR_A;
          end else if (eof_close) begin
            state <= ST_DONE;
          end else begin
            if (counter != srl_pkg::CNT_MAX) begin
              counter <= counter + 16'd1;
            end
            fill  <= '0;
            phase <= srl_pkg::PH_TYPE;
            state <= ST_IDLE;
          end
        end
        ST_ERR: begin
          if (slot_free) begin
            out_kind  <= err_kind;
            out_addr  <= '0;
            out_data  <= '0;
            out_rec   <= counter;
            out_last  <= !eof_close;
            halted    <= 1'b1;
            state     <= eof_close ? ST_DONE : ST_IDLE;
          end
        end
        ST_WR_A: begin
          state <= ST_WR_B;
        end
        ST_WR_B: begin
          hi    <= rdata;
          state <= ST_WR_C;
        end
        ST_WR_C: begin
          if (slot_free) begin
            out_kind  <= srl_pkg::RK_WRITE;
            out_addr  <= wr_addr;
            out_data  <= rd_byte;
            out_rec   <= counter;
            out_last  <= !eof_close && !more_wr;
            wr_addr   <= wr_addr + 16'd1;
            idx       <= idx + srl_pkg::FILL_W'(2);
            if (more_wr) begin
              state <= ST_WR_A;
            end else if (eof_close) begin
              state <= ST_DONE;
            end else begin
              if (counter != srl_pkg::CNT_MAX) begin
                counter <= counter + 16'd1;
              end
              fill  <= '0;
              phase <= srl_pkg::PH_TYPE;
              state <= ST_IDLE;
            end
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_kind  <= srl_pkg::RK_DONE;
            out_addr  <= '0;
            out_data  <= '0;
            out_rec   <= counter;
            out_last  <= 1'b1;
            counter   <= '0;
            fill      <= '0;
            phase     <= srl_pkg::PH_WAIT;
            halted    <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        ST_LONG: begin
          if (slot_free) begin
            out_kind  <= srl_pkg::RK_LONG;
            out_addr  <= '0;
            out_data  <= '0;
            out_rec   <= counter;
            out_last  <= 1'b1;
            halted    <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the S-record loader. Plain tasks stream whole
// S1/S9 files (well-formed, damaged and noisy) one character per beat, each
// closed by an end-of-file beat. A scoreboard class keeps its own copy of
// the loader state, predicts the byte writes, error and done results of
// every accepted beat, and compares each result beat field by field in
// order. Sender gaps and receiver stalls vary by phase, and one long
// receiver hold-off backs the loader up into its input.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int FLAW_NONE   = 0;
  localparam int FLAW_LEN    = 1;
  localparam int FLAW_SUM    = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [15:0] rec_num;
    logic        last;
  } srec_result_t;

  class srec_predictor;
    logic [3:0]   nibbles [srl_pkg::NIBBLE_DEPTH];
    int           fill;
    logic [1:0]   phase;
    logic [15:0]  rec_count;
    bit           halted;
    srec_result_t due_results [$];
    int           mismatches;

    function new();
      clear_file();
      mismatches = 0;
    endfunction

    function void clear_file();
      fill      = 0;
      phase     = srl_pkg::PH_WAIT;
      rec_count = 16'd0;
      halted    = 1'b0;
    endfunction

    // digits never received read as zero
    function logic [3:0] nib(int i);
      return (i < fill) ? nibbles[i] : 4'h0;
    endfunction

    function void emit(logic [2:0] kind, logic [15:0] addr, logic [7:0] data);
      due_results.push_back('{kind, addr, data, rec_count, 1'b0});
    endfunction

    function logic [2:0] record_fault();
      int         want;
      logic [7:0] sum;
      want = (int'({nib(0), nib(1)}) + 1) * 2;
      if (want != fill) return srl_pkg::RK_LEN;
      sum = 8'd0;
      for (int i = 0; i + 1 < fill; i += 2) sum += {nib(i), nib(i + 1)};
      return (sum == srl_pkg::SUM_OK) ? srl_pkg::RK_WRITE : srl_pkg::RK_SUM;
    endfunction

    function void close_record(bit store);
      logic [2:0]  fault;
      logic [15:0] addr;
      fault = record_fault();
      if (fault != srl_pkg::RK_WRITE) begin
        emit(fault, 16'd0, 8'd0);
        halted = 1'b1;
        return;
      end
      if (!store) return;
      addr = {nib(2), nib(3), nib(4), nib(5)};
      for (int i = 6; i + 3 < fill; i += 2) begin
        emit(srl_pkg::RK_WRITE, addr, {nib(i), nib(i + 1)});
        addr++;
      end
    endfunction

    function void take_char(bit eof, logic [7:0] ch);
      int         start;
      logic [3:0] v;
      bit         hex;
      start = due_results.size();
      if (eof) begin
        if (!halted) begin
          if (phase == srl_pkg::PH_S1) close_record(1'b1);
          else if (phase == srl_pkg::PH_S9) close_record(1'b0);
        end
        emit(srl_pkg::RK_DONE, 16'd0, 8'd0);
        clear_file();
      end else if (!halted) begin
        if (ch == srl_pkg::CH_S_UP || ch == srl_pkg::CH_S_LO) begin
          if (phase == srl_pkg::PH_S1) close_record(1'b1);
          if (!halted) begin
            if (rec_count < srl_pkg::CNT_MAX) rec_count++;
            fill  = 0;
            phase = srl_pkg::PH_TYPE;
          end
        end else if (phase == srl_pkg::PH_TYPE) begin
          if (ch == srl_pkg::CH_ONE) phase = srl_pkg::PH_S1;
          else if (ch == srl_pkg::CH_NINE) phase = srl_pkg::PH_S9;
          else phase = srl_pkg::PH_WAIT;
        end else if (phase == srl_pkg::PH_WAIT) begin
        end else if (fill < srl_pkg::NIBBLE_DEPTH) begin
          hex = 1'b1;
          v   = 4'h0;
          if (ch >= "0" && ch <= "9") v = 4'(ch - "0");
          else if (ch >= "A" && ch <= "F") v = 4'(ch - "A" + 8'd10);
          else if (ch >= "a" && ch <= "f") v = 4'(ch - "a" + 8'd10);
          else hex = 1'b0;
          if (hex) begin
            nibbles[fill] = v;
            fill++;
          end
        end else begin
          emit(srl_pkg::RK_LONG, 16'd0, 8'd0);
          halted = 1'b1;
        end
      end
      if (due_results.size() > start) due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    function void match_result(srec_result_t got);
      srec_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d addr %h data %h rec %0d last %b",
                   got.kind, got.address, got.data, got.rec_num, got.last);
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.address !== want.address ||
          got.data !== want.data || got.rec_num !== want.rec_num ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind %0d addr %h data %h rec %0d last %b, ",
                   want.kind, want.address, want.data, want.rec_num, want.last,
                   "got kind %0d addr %h data %h rec %0d last %b",
                   got.kind, got.address, got.data, got.rec_num, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   snd_idle;
  int   rcv_stall;
  bit   hold_off;
  int   chars_sent;
  logic [7:0] file_text [$];
  srec_predictor board = new();

  srl_in_if  chars_if ();
  srl_out_if results_if ();

  s_record_loader u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    results_if.ready = !hold_off && ($urandom_range(99) >= rcv_stall);
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      board.match_result('{results_if.result_kind, results_if.write_address,
                           results_if.write_data, results_if.record_number,
                           results_if.last});
  end

  task automatic send_beat(bit eof, logic [7:0] ch);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      chars_if.valid = 1'b0;
      @(negedge clk);
    end
    chars_if.valid     = 1'b1;
    chars_if.kind      = eof;
    chars_if.character = ch;
    do @(posedge clk); while (!chars_if.ready);
    board.take_char(eof, ch);
    chars_sent++;
  endtask

  task automatic send_file();
    foreach (file_text[i]) send_beat(1'b0, file_text[i]);
    send_beat(1'b1, 8'($urandom_range(255)));
    file_text.delete();
  endtask

  function automatic bit is_hex(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (is_hex(c) || c == srl_pkg::CH_S_UP || c == srl_pkg::CH_S_LO);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return "0" + 8'(n);
    return (lower ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  function automatic void add_byte(logic [7:0] b, bit lower);
    if ($urandom_range(19) == 0) file_text.push_back(junk_char());
    file_text.push_back(hex_char(b[7:4], lower));
    file_text.push_back(hex_char(b[3:0], lower));
  endfunction

  function automatic void add_record(logic [7:0] type_ch, logic [15:0] addr, int ndata,
                                     int flaw, bit lower);
    logic [7:0] cnt;
    logic [7:0] sum;
    logic [7:0] b;
    cnt = 8'(ndata + 3);
    file_text.push_back(lower ? srl_pkg::CH_S_LO : srl_pkg::CH_S_UP);
    file_text.push_back(type_ch);
    sum = cnt + addr[15:8] + addr[7:0];
    if (flaw == FLAW_LEN) cnt = cnt + 8'($urandom_range(1, 5));
    add_byte(cnt, lower);
    add_byte(addr[15:8], lower);
    add_byte(addr[7:0], lower);
    for (int i = 0; i < ndata; i++) begin
      b = 8'($urandom_range(255));
      sum += b;
      add_byte(b, lower);
    end
    sum = ~sum;
    if (flaw == FLAW_SUM) sum ^= 8'($urandom_range(1, 255));
    add_byte(sum, lower);
  endfunction

  function automatic logic [15:0] pick_addr();
    if ($urandom_range(3) == 0) return 16'hFFFF - 16'($urandom_range(3));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic void build_random_file();
    int         sel;
    logic [7:0] t;
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 4)) file_text.push_back(8'($urandom_range(255)));
    repeat ($urandom_range(1, 3)) begin
      sel = $urandom_range(99);
      if (sel < 70)
        add_record(srl_pkg::CH_ONE, pick_addr(),
                   ($urandom_range(11) == 0) ? 60 : $urandom_range(6),
                   FLAW_NONE, 1'($urandom_range(1)));
      else if (sel < 77)
        add_record(srl_pkg::CH_ONE, pick_addr(), $urandom_range(6), FLAW_SUM,
                   1'($urandom_range(1)));
      else if (sel < 84)
        add_record(srl_pkg::CH_ONE, pick_addr(), $urandom_range(6), FLAW_LEN,
                   1'($urandom_range(1)));
      else if (sel < 90)
        add_record(srl_pkg::CH_NINE, pick_addr(), 0, FLAW_NONE, 1'($urandom_range(1)));
      else if (sel < 94) begin
        do t = 8'($urandom_range(255));
        while (t == srl_pkg::CH_ONE || t == srl_pkg::CH_NINE ||
               t == srl_pkg::CH_S_UP || t == srl_pkg::CH_S_LO);
        add_record(t, pick_addr(), $urandom_range(3), FLAW_NONE, 1'($urandom_range(1)));
      end else if (sel < 97)
        add_record(srl_pkg::CH_NINE, pick_addr(), 0, FLAW_SUM, 1'($urandom_range(1)));
      else
        add_record(srl_pkg::CH_ONE, pick_addr(), $urandom_range(62, 70), FLAW_NONE,
                   1'($urandom_range(1)));
    end
    if ($urandom_range(1) == 0)
      add_record(srl_pkg::CH_NINE, pick_addr(), 0, FLAW_NONE, 1'b0);
  endfunction

  task automatic run_phase(int idle_pct, int stall_pct, int quota);
    int start;
    snd_idle  = idle_pct;
    rcv_stall = stall_pct;
    start     = chars_sent;
    while (chars_sent - start < quota) begin
      build_random_file();
      send_file();
    end
  endtask

  initial begin
    rst                = 1'b1;
    cycles             = 0;
    snd_idle           = 0;
    rcv_stall          = 0;
    hold_off           = 1'b0;
    chars_sent         = 0;
    chars_if.valid     = 1'b0;
    chars_if.kind      = 1'b0;
    chars_if.character = 8'd0;
    results_if.ready   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty file
    send_file();

    // header record, address wrap, empty data record, lowercase, end record
    file_text = '{8'h00, 8'hFF, srl_pkg::CH_S_UP, "0", "0", "F", "0", "0"};
    add_record(srl_pkg::CH_ONE, 16'hFFFE, 4, FLAW_NONE, 1'b0);
    add_record(srl_pkg::CH_ONE, 16'h1234, 0, FLAW_NONE, 1'b1);
    add_record(srl_pkg::CH_ONE, 16'hABCD, 3, FLAW_NONE, 1'b1);
    add_record(srl_pkg::CH_NINE, 16'h0000, 0, FLAW_NONE, 1'b0);
    send_file();

    // checksum error halts until end of file
    add_record(srl_pkg::CH_ONE, 16'h0100, 2, FLAW_SUM, 1'b0);
    add_record(srl_pkg::CH_ONE, 16'h0200, 2, FLAW_NONE, 1'b0);
    send_file();

    // length error found at end of file
    add_record(srl_pkg::CH_ONE, 16'h0300, 3, FLAW_LEN, 1'b0);
    send_file();

    // bad end record
    add_record(srl_pkg::CH_ONE, 16'h0400, 1, FLAW_NONE, 1'b0);
    add_record(srl_pkg::CH_NINE, 16'h0400, 0, FLAW_SUM, 1'b0);
    send_file();

    // unknown type, then end of file while waiting for the type
    file_text = '{srl_pkg::CH_S_UP, "X", "1", "2", srl_pkg::CH_S_LO};
    send_file();

    // store overflow
    add_record(srl_pkg::CH_ONE, 16'h0500, 64, FLAW_NONE, 1'b0);
    file_text.push_back(srl_pkg::CH_S_UP);
    send_file();

    // long output hold-off so the loader backs up
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    add_record(srl_pkg::CH_ONE, 16'h7000, 20, FLAW_NONE, 1'b0);
    add_record(srl_pkg::CH_ONE, 16'hFFF0, 20, FLAW_NONE, 1'b1);
    send_file();

    run_phase(0, 0, 20);
    run_phase(80, 0, 20);
    run_phase(0, 80, 20);
    run_phase(26, 26, 20);

    @(negedge clk);
    chars_if.valid = 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (board.due_results.size() != 0)
      $display("results never arrived: %0d", board.due_results.size());
    if (board.mismatches == 0 && board.due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("mismatches: %0d", board.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
